@@ rtl/hfn_pkg.sv @@
// ----------------------------------------------------------------------------
// Heightfield normal map package
// Shared types and constants for the normal map pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package hfn_pkg;

  localparam int unsigned UNIT_BITS = 30;
  localparam int unsigned ROOT_BITS = 31;

  localparam logic [24:0] SQRT2_Q24     = 25'd23726566;
  localparam logic [29:0] INV_SQRT2_Q30 = 30'd759250125;
  localparam logic [15:0] OUT_SCALE     = 16'hFFFF;
  localparam logic signed [31:0] Q30_ONE = 32'sh4000_0000;

  localparam logic [1:0] CFG_GRID_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_GRID_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_FLAT_TERM   = 2'd2;

  localparam int unsigned WIN_CENTER     = 0;
  localparam int unsigned WIN_RIGHT      = 1;
  localparam int unsigned WIN_UP         = 2;
  localparam int unsigned WIN_LEFT       = 3;
  localparam int unsigned WIN_DOWN       = 4;
  localparam int unsigned WIN_DOWN_RIGHT = 5;
  localparam int unsigned WIN_UP_LEFT    = 6;
  localparam int unsigned WIN_DOWN_LEFT  = 7;
  localparam int unsigned WIN_UP_RIGHT   = 8;

  typedef struct packed {
    logic [15:0] grid_width;
    logic [15:0] grid_height;
    logic [15:0] flat_term;
  } cfg_t;

  typedef logic signed [31:0] unit_t;

endpackage

`default_nettype wire

@@ rtl/hfn_front.sv @@
// ----------------------------------------------------------------------------
// Heightfield normal map front end
// Edge substitution of the neighbor heights and the raw axis and diagonal
// vectors, two register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module hfn_front
  import hfn_pkg::*;
#(
  parameter int unsigned HEIGHT_BITS = 16,
  parameter int unsigned MAG_W       = 48
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  cfg_t                        cfg_i,
  input  logic [15:0]                 col_i,
  input  logic [15:0]                 row_i,
  input  logic [8:0][15:0]            win_i,
  output logic                        valid_o,
  output logic [2:0]                  axis_neg_o,
  output logic [2:0][MAG_W-1:0]       axis_mag_o,
  output logic [2:0]                  diag_neg_o,
  output logic [2:0][MAG_W-1:0]       diag_mag_o
);

  localparam int unsigned HW = (HEIGHT_BITS < 16) ? HEIGHT_BITS : 16;

  function automatic logic [HW:0] sdiff(input logic [HW-1:0] p, input logic [HW-1:0] q);
    logic [HW:0] r;
    if (p >= q) begin
      r = {1'b0, p - q};
    end else begin
      r = {1'b1, q - p};
    end
    return r;
  endfunction

  logic          ok_r, ok_d, ok_l, ok_u;
  logic [HW-1:0] ctr;
  logic [HW-1:0] a_d, b_d, c_d, d_d, x_d, y_d, z_d, w_d;
  logic          v1_q;
  logic [HW-1:0] a_q, b_q, c_q, d_q, x_q, y_q, z_q, w_q;
  logic [15:0]   flat_q;

  always_comb begin
    ok_r = ({1'b0, col_i} + 17'd1) < {1'b0, cfg_i.grid_width};
    ok_d = ({1'b0, row_i} + 17'd1) < {1'b0, cfg_i.grid_height};
    ok_l = |col_i[15:1];
    ok_u = |row_i[15:1];
    ctr  = win_i[WIN_CENTER][HW-1:0];
    a_d  = ok_r ? win_i[WIN_RIGHT][HW-1:0] : ctr;
    b_d  = ok_u ? win_i[WIN_UP][HW-1:0] : ctr;
    c_d  = ok_l ? win_i[WIN_LEFT][HW-1:0] : ctr;
    d_d  = ok_d ? win_i[WIN_DOWN][HW-1:0] : ctr;
    x_d  = (ok_r && ok_d) ? win_i[WIN_DOWN_RIGHT][HW-1:0] : ctr;
    y_d  = (ok_l && ok_u) ? win_i[WIN_UP_LEFT][HW-1:0] : ctr;
    z_d  = (ok_l && ok_d) ? win_i[WIN_DOWN_LEFT][HW-1:0] : ctr;
    w_d  = (ok_r && ok_u) ? win_i[WIN_UP_RIGHT][HW-1:0] : ctr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= valid_i && !row_i[0] && !col_i[0];
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    c_q    <= c_d;
    d_q    <= d_d;
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    w_q    <= w_d;
    flat_q <= cfg_i.flat_term;
  end

  logic [HW:0]             dax, day, ddx, ddy;
  logic [40:0]             zdiag;
  logic [2:0]              axis_neg_d, diag_neg_d;
  logic [2:0][MAG_W-1:0]   axis_mag_d, diag_mag_d;
  logic                    v2_q;

  always_comb begin
    dax   = sdiff(c_q, a_q);
    day   = sdiff(b_q, d_q);
    ddx   = sdiff(z_q, w_q);
    ddy   = sdiff(y_q, x_q);
    zdiag = 41'(flat_q) * 41'(SQRT2_Q24);
    axis_neg_d    = {1'b0, day[HW], dax[HW]};
    diag_neg_d    = {1'b0, ddy[HW], ddx[HW]};
    axis_mag_d[0] = MAG_W'({dax[HW-1:0], 32'b0});
    axis_mag_d[1] = MAG_W'({day[HW-1:0], 32'b0});
    axis_mag_d[2] = MAG_W'({flat_q, 24'b0});
    diag_mag_d[0] = MAG_W'({ddx[HW-1:0], 32'b0});
    diag_mag_d[1] = MAG_W'({ddy[HW-1:0], 32'b0});
    diag_mag_d[2] = MAG_W'(zdiag);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    axis_neg_o <= axis_neg_d;
    axis_mag_o <= axis_mag_d;
    diag_neg_o <= diag_neg_d;
    diag_mag_o <= diag_mag_d;
  end

  assign valid_o = v2_q;

endmodule

`default_nettype wire

@@ rtl/hfn_unitize.sv @@
// ----------------------------------------------------------------------------
// Heightfield normal map vector normalizer
// Scales a sign-magnitude vector below 2^30, takes the integer square root
// of its squared length one bit per stage and divides each component by it
// one quotient bit per stage, giving Q30 unit components.
// ----------------------------------------------------------------------------
`default_nettype none

module hfn_unitize
  import hfn_pkg::*;
#(
  parameter int unsigned MAG_W = 48
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic [2:0]            in_neg_i,
  input  logic [2:0][MAG_W-1:0] in_mag_i,
  output logic                  out_valid_o,
  output unit_t [2:0]           out_u_o
);

  localparam int unsigned SH_W  = $clog2(MAG_W + 1);
  localparam int unsigned NS    = ROOT_BITS;
  localparam int unsigned SUM_W = 2 * UNIT_BITS + 2;
  localparam int unsigned SQ_W  = 2 * UNIT_BITS;

  // Normalizing shift.
  logic [MAG_W-1:0]       or_mag;
  logic [SH_W-1:0]        blen, sh_d;
  logic                   v1_q;
  logic [2:0]             neg1_q;
  logic [2:0][MAG_W-1:0]  mag1_q;
  logic [SH_W-1:0]        sh1_q;

  always_comb begin
    or_mag = in_mag_i[0] | in_mag_i[1] | in_mag_i[2];
    blen   = '0;
    for (int b = 0; b < MAG_W; b++) begin
      if (or_mag[b]) begin
        blen = SH_W'(b + 1);
      end
    end
    sh_d = (blen > SH_W'(UNIT_BITS)) ? blen - SH_W'(UNIT_BITS) : '0;
  end

  logic                      v2_q, v3_q, v4_q;
  logic [2:0]                neg2_q, neg3_q, neg4_q;
  logic [2:0][MAG_W-1:0]     shifted;
  logic [2:0][UNIT_BITS-1:0] m2_d, m2_q, m3_q, m4_q;
  logic [2:0][SQ_W-1:0]      sq3_d, sq3_q;
  logic [SUM_W-1:0]          sum4_d, sum4_q;
  logic                      zero4_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      shifted[c] = mag1_q[c] >> sh1_q;
      m2_d[c]    = shifted[c][UNIT_BITS-1:0];
      sq3_d[c]   = SQ_W'(m2_q[c]) * SQ_W'(m2_q[c]);
    end
    sum4_d = SUM_W'(sq3_q[0]) + SUM_W'(sq3_q[1]) + SUM_W'(sq3_q[2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    neg1_q  <= in_neg_i;
    mag1_q  <= in_mag_i;
    sh1_q   <= sh_d;
    neg2_q  <= neg1_q;
    m2_q    <= m2_d;
    neg3_q  <= neg2_q;
    m3_q    <= m2_q;
    sq3_q   <= sq3_d;
    neg4_q  <= neg3_q;
    m4_q    <= m3_q;
    sum4_q  <= sum4_d;
    zero4_q <= (sum4_d == '0);
  end

  // Square root, one root bit per stage.
  logic                      sv_q    [NS];
  logic [2:0]                sneg_q  [NS];
  logic                      szero_q [NS];
  logic [2:0][UNIT_BITS-1:0] sm_q    [NS];
  logic [SUM_W-1:0]          srem_q  [NS];
  logic [ROOT_BITS-1:0]      sroot_q [NS];

  for (genvar i = 0; i < NS; i++) begin : g_sqrt
    logic                      v_in, z_in;
    logic [2:0]                n_in;
    logic [2:0][UNIT_BITS-1:0] m_in;
    logic [SUM_W-1:0]          r_in, trial, rem_d;
    logic [ROOT_BITS-1:0]      root_in, root_d;

    if (i == 0) begin : g_first
      assign v_in    = v4_q;
      assign z_in    = zero4_q;
      assign n_in    = neg4_q;
      assign m_in    = m4_q;
      assign r_in    = sum4_q;
      assign root_in = '0;
    end else begin : g_next
      assign v_in    = sv_q[i-1];
      assign z_in    = szero_q[i-1];
      assign n_in    = sneg_q[i-1];
      assign m_in    = sm_q[i-1];
      assign r_in    = srem_q[i-1];
      assign root_in = sroot_q[i-1];
    end

    always_comb begin
      trial = (SUM_W'(root_in) << (NS - i)) | (SUM_W'(1) << (2 * (NS - 1 - i)));
      if (r_in >= trial) begin
        rem_d  = r_in - trial;
        root_d = root_in | (ROOT_BITS'(1) << (NS - 1 - i));
      end else begin
        rem_d  = r_in;
        root_d = root_in;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[i] <= 1'b0;
      end else begin
        sv_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      szero_q[i] <= z_in;
      sneg_q[i]  <= n_in;
      sm_q[i]    <= m_in;
      srem_q[i]  <= rem_d;
      sroot_q[i] <= root_d;
    end
  end

  // Division of each component by the length, one quotient bit per stage.
  logic                      dv_q    [NS];
  logic [2:0]                dneg_q  [NS];
  logic                      dzero_q [NS];
  logic [ROOT_BITS-1:0]      dlen_q  [NS];
  logic [2:0][ROOT_BITS-1:0] drem_q  [NS];
  logic [2:0][ROOT_BITS-1:0] dquo_q  [NS];

  for (genvar j = 0; j < NS; j++) begin : g_div
    logic                      v_in, z_in;
    logic [2:0]                n_in;
    logic [ROOT_BITS-1:0]      len_in;
    logic [2:0][ROOT_BITS-1:0] r_in, q_in, rem_d, quo_d;
    logic [2:0]                b_in;
    logic [2:0][ROOT_BITS:0]   r2, dif;

    if (j == 0) begin : g_first
      assign v_in   = sv_q[NS-1];
      assign z_in   = szero_q[NS-1];
      assign n_in   = sneg_q[NS-1];
      assign len_in = sroot_q[NS-1];
      for (genvar c = 0; c < 3; c++) begin : g_load
        assign r_in[c] = ROOT_BITS'(sm_q[NS-1][c][UNIT_BITS-1:1]);
        assign b_in[c] = sm_q[NS-1][c][0];
      end
      assign q_in   = '0;
    end else begin : g_next
      assign v_in   = dv_q[j-1];
      assign z_in   = dzero_q[j-1];
      assign n_in   = dneg_q[j-1];
      assign len_in = dlen_q[j-1];
      assign r_in   = drem_q[j-1];
      assign b_in   = '0;
      assign q_in   = dquo_q[j-1];
    end

    always_comb begin
      for (int c = 0; c < 3; c++) begin
        r2[c]  = {r_in[c], b_in[c]};
        dif[c] = r2[c] - {1'b0, len_in};
        if (r2[c] >= {1'b0, len_in}) begin
          rem_d[c] = dif[c][ROOT_BITS-1:0];
          quo_d[c] = q_in[c] | (ROOT_BITS'(1) << (NS - 1 - j));
        end else begin
          rem_d[c] = r2[c][ROOT_BITS-1:0];
          quo_d[c] = q_in[c];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[j] <= 1'b0;
      end else begin
        dv_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      dzero_q[j] <= z_in;
      dneg_q[j]  <= n_in;
      dlen_q[j]  <= len_in;
      drem_q[j]  <= rem_d;
      dquo_q[j]  <= quo_d;
    end
  end

  // Sign and the zero-length case.
  unit_t [2:0] u_d;
  logic        vo_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (dzero_q[NS-1]) begin
        u_d[c] = (c == 2) ? Q30_ONE : '0;
      end else if (dneg_q[NS-1][c]) begin
        u_d[c] = -unit_t'({1'b0, dquo_q[NS-1][c]});
      end else begin
        u_d[c] = unit_t'({1'b0, dquo_q[NS-1][c]});
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else begin
      vo_q <= dv_q[NS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    out_u_o <= u_d;
  end

  assign out_valid_o = vo_q;

endmodule

`default_nettype wire

@@ rtl/hfn_blend.sv @@
// ----------------------------------------------------------------------------
// Heightfield normal map blend
// Adds the diagonal unit vector scaled by 1/sqrt(2) to the axis unit vector
// and hands the sum on in sign-magnitude form, three register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module hfn_blend
  import hfn_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  unit_t [2:0]               axis_i,
  input  unit_t [2:0]               diag_i,
  output logic                      valid_o,
  output logic [2:0]                neg_o,
  output logic [2:0][ROOT_BITS-1:0] mag_o
);

  localparam int unsigned PROD_W = ROOT_BITS + UNIT_BITS;

  unit_t [2:0]              dabs;
  logic [2:0][PROD_W-1:0]   prod_d, prod_q;
  logic [2:0]               dneg_q;
  unit_t [2:0]              axis_q;
  unit_t [2:0]              scaled, sum_d, sum_q, sabs;
  logic [2:0]               neg_d;
  logic [2:0][ROOT_BITS-1:0] mag_d;
  logic                     v1_q, v2_q, v3_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      dabs[c]   = diag_i[c][31] ? -diag_i[c] : diag_i[c];
      prod_d[c] = PROD_W'(dabs[c][ROOT_BITS-1:0]) * PROD_W'(INV_SQRT2_Q30);
      scaled[c] = unit_t'({1'b0, prod_q[c][PROD_W-1:UNIT_BITS]});
      sum_d[c]  = dneg_q[c] ? axis_q[c] - scaled[c] : axis_q[c] + scaled[c];
      neg_d[c]  = sum_q[c][31];
      sabs[c]   = sum_q[c][31] ? -sum_q[c] : sum_q[c];
      mag_d[c]  = sabs[c][ROOT_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    for (int c = 0; c < 3; c++) begin
      dneg_q[c] <= diag_i[c][31];
    end
    axis_q <= axis_i;
    sum_q  <= sum_d;
    neg_o  <= neg_d;
    mag_o  <= mag_d;
  end

  assign valid_o = v3_q;

endmodule

`default_nettype wire

@@ rtl/hfn_encode.sv @@
// ----------------------------------------------------------------------------
// Heightfield normal map output encoder
// Maps each Q30 unit component from [-1, 1] onto 0 to 65535, truncated.
// ----------------------------------------------------------------------------
`default_nettype none

module hfn_encode
  import hfn_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  unit_t [2:0]      u_i,
  output logic             valid_o,
  output logic [2:0][15:0] code_o
);

  logic [2:0][31:0] t;
  logic [2:0][47:0] prod_d, prod_q;
  logic [2:0][15:0] code_d;
  logic             v1_q, v2_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      t[c]      = 32'(u_i[c] + Q30_ONE);
      prod_d[c] = 48'(t[c]) * 48'(OUT_SCALE);
      code_d[c] = prod_q[c][46:31];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    code_o <= code_d;
  end

  assign valid_o = v2_q;

endmodule

`default_nettype wire

@@ rtl/heightfield_normal_map_unit.sv @@
// ----------------------------------------------------------------------------
// Heightfield normal map unit
// Turns a 3x3 heightfield window into a blended axis and diagonal surface
// normal, encoded as three 16-bit components.
// ----------------------------------------------------------------------------
// The unit takes one window per clock cycle and never raises busy_o. A window
// whose row or column is odd gives no result; every other window gives one
// result, shown for a single cycle with done_o high. The path runs through the
// two normalizers in series, each of which takes the square root one bit per
// stage and divides one quotient bit per stage. The receiver cannot stall the
// unit, and results leave in the order the windows came in. Configuration
// writes are always accepted and must be made while no window is in flight.
`default_nettype none

module heightfield_normal_map_unit
  import hfn_pkg::*;
#(
  parameter int unsigned HEIGHT_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [15:0] col_i,
  input  logic [15:0] row_i,
  input  logic [15:0] h_center_i,
  input  logic [15:0] h_right_i,
  input  logic [15:0] h_up_i,
  input  logic [15:0] h_left_i,
  input  logic [15:0] h_down_i,
  input  logic [15:0] h_down_right_i,
  input  logic [15:0] h_up_left_i,
  input  logic [15:0] h_down_left_i,
  input  logic [15:0] h_up_right_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output logic        done_o,
  output logic [15:0] normal_x_o,
  output logic [15:0] normal_y_o,
  output logic [15:0] normal_z_o
);

  localparam int unsigned HW    = (HEIGHT_BITS < 16) ? HEIGHT_BITS : 16;
  localparam int unsigned MAG_W = (HW + 32 > 41) ? HW + 32 : 41;

  localparam logic [15:0] GRID_WIDTH_RST  = 16'd4096;
  localparam logic [15:0] GRID_HEIGHT_RST = 16'd4096;
  localparam logic [15:0] FLAT_TERM_RST   = 16'd256;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.grid_width  <= GRID_WIDTH_RST;
      cfg_q.grid_height <= GRID_HEIGHT_RST;
      cfg_q.flat_term   <= FLAT_TERM_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_GRID_WIDTH: begin
          cfg_q.grid_width <= cfg_data_i;
        end
        CFG_GRID_HEIGHT: begin
          cfg_q.grid_height <= cfg_data_i;
        end
        CFG_FLAT_TERM: begin
          cfg_q.flat_term <= cfg_data_i;
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;

  logic [8:0][15:0] win;

  always_comb begin
    win                 = '0;
    win[WIN_CENTER]     = h_center_i;
    win[WIN_RIGHT]      = h_right_i;
    win[WIN_UP]         = h_up_i;
    win[WIN_LEFT]       = h_left_i;
    win[WIN_DOWN]       = h_down_i;
    win[WIN_DOWN_RIGHT] = h_down_right_i;
    win[WIN_UP_LEFT]    = h_up_left_i;
    win[WIN_DOWN_LEFT]  = h_down_left_i;
    win[WIN_UP_RIGHT]   = h_up_right_i;
  end

  logic                      front_valid;
  logic [2:0]                axis_neg, diag_neg;
  logic [2:0][MAG_W-1:0]     axis_mag, diag_mag;

  hfn_front #(
    .HEIGHT_BITS (HEIGHT_BITS),
    .MAG_W       (MAG_W)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (start_i && !busy_o),
    .cfg_i      (cfg_q),
    .col_i      (col_i),
    .row_i      (row_i),
    .win_i      (win),
    .valid_o    (front_valid),
    .axis_neg_o (axis_neg),
    .axis_mag_o (axis_mag),
    .diag_neg_o (diag_neg),
    .diag_mag_o (diag_mag)
  );

  logic        axis_valid, diag_valid;
  unit_t [2:0] axis_u, diag_u;

  hfn_unitize #(
    .MAG_W (MAG_W)
  ) u_axis_unit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (front_valid),
    .in_neg_i    (axis_neg),
    .in_mag_i    (axis_mag),
    .out_valid_o (axis_valid),
    .out_u_o     (axis_u)
  );

  hfn_unitize #(
    .MAG_W (MAG_W)
  ) u_diag_unit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (front_valid),
    .in_neg_i    (diag_neg),
    .in_mag_i    (diag_mag),
    .out_valid_o (diag_valid),
    .out_u_o     (diag_u)
  );

  logic                      blend_valid;
  logic [2:0]                blend_neg;
  logic [2:0][ROOT_BITS-1:0] blend_mag;

  hfn_blend u_blend (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (axis_valid && diag_valid),
    .axis_i  (axis_u),
    .diag_i  (diag_u),
    .valid_o (blend_valid),
    .neg_o   (blend_neg),
    .mag_o   (blend_mag)
  );

  logic        sum_valid;
  unit_t [2:0] sum_u;

  hfn_unitize #(
    .MAG_W (ROOT_BITS)
  ) u_sum_unit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (blend_valid),
    .in_neg_i    (blend_neg),
    .in_mag_i    (blend_mag),
    .out_valid_o (sum_valid),
    .out_u_o     (sum_u)
  );

  logic [2:0][15:0] code;

  hfn_encode u_encode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sum_valid),
    .u_i     (sum_u),
    .valid_o (done_o),
    .code_o  (code)
  );

  assign normal_x_o = code[0];
  assign normal_y_o = code[1];
  assign normal_z_o = code[2];

endmodule

`default_nettype wire

@@ bench/hfn_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heightfield normal map checker
// Watches the window, configuration and result channels of the normal map
// unit, computes the expected normal for every even window and compares it
// field by field with the results in order.
// ----------------------------------------------------------------------------
`default_nettype none

module hfn_checker
  import hfn_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [15:0] col_i,
  input  logic [15:0] row_i,
  input  logic [15:0] h_center_i,
  input  logic [15:0] h_right_i,
  input  logic [15:0] h_up_i,
  input  logic [15:0] h_left_i,
  input  logic [15:0] h_down_i,
  input  logic [15:0] h_down_right_i,
  input  logic [15:0] h_up_left_i,
  input  logic [15:0] h_down_left_i,
  input  logic [15:0] h_up_right_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        done_i,
  input  logic [15:0] normal_x_i,
  input  logic [15:0] normal_y_i,
  input  logic [15:0] normal_z_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          normals_seen_o
);

  typedef struct {
    logic [15:0] nx;
    logic [15:0] ny;
    logic [15:0] nz;
  } normal_t;

  normal_t normal_queue[$];
  logic [15:0] width_q, height_q, flat_q;

  function automatic longint unsigned root_floor(longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic void to_unit(input longint v[3], output longint u[3]);
    longint unsigned m[3], mx, sum, len;
    bit neg[3];
    int s;
    mx = 0;
    sum = 0;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = v[i] < 0;
      m[i] = neg[i] ? -v[i] : v[i];
      if (m[i] > mx) mx = m[i];
    end
    while (s < 63 && (mx >> s) >= (64'd1 << 30)) s++;
    for (int i = 0; i < 3; i++) begin
      m[i] >>= s;
      sum += m[i] * m[i];
    end
    if (sum == 0) begin
      u[0] = 0;
      u[1] = 0;
      u[2] = 64'sd1 << 30;
    end else begin
      len = root_floor(sum);
      for (int i = 0; i < 3; i++) begin
        longint q;
        q = longint'((m[i] << 30) / len);
        u[i] = neg[i] ? -q : q;
      end
    end
  endfunction

  function automatic longint diag_scale(longint a);
    longint unsigned m;
    longint q;
    m = (a < 0) ? -a : a;
    q = longint'((m * 64'(INV_SQRT2_Q30)) >> 30);
    return (a < 0) ? -q : q;
  endfunction

  function automatic longint height_diff(longint unsigned p, longint unsigned q);
    if (p >= q) return longint'((p - q) << 32);
    return -longint'((q - p) << 32);
  endfunction

  function automatic logic [15:0] encode(longint u);
    longint unsigned t;
    t = longint'(u + (64'sd1 << 30));
    return 16'((t * 65535) >> 31);
  endfunction

  function automatic normal_t surface_normal(
    logic [15:0] col, logic [15:0] row, logic [15:0] hc, logic [15:0] hr,
    logic [15:0] hu, logic [15:0] hl, logic [15:0] hd, logic [15:0] hdr,
    logic [15:0] hul, logic [15:0] hdl, logic [15:0] hur);
    bit ok_r, ok_d, ok_l, ok_u;
    longint unsigned a, b, c, d, x, y, z, w;
    longint v1[3], v2[3], n1[3], n2[3], sm[3], n[3];
    normal_t res;
    ok_r = 32'(col) + 1 < 32'(width_q);
    ok_d = 32'(row) + 1 < 32'(height_q);
    ok_l = col >= 2;
    ok_u = row >= 2;
    a = ok_r ? hr : hc;
    b = ok_u ? hu : hc;
    c = ok_l ? hl : hc;
    d = ok_d ? hd : hc;
    x = (ok_r && ok_d) ? hdr : hc;
    y = (ok_l && ok_u) ? hul : hc;
    z = (ok_l && ok_d) ? hdl : hc;
    w = (ok_r && ok_u) ? hur : hc;
    v1[0] = height_diff(c, a);
    v1[1] = height_diff(b, d);
    v1[2] = longint'(64'(flat_q) << 24);
    v2[0] = height_diff(z, w);
    v2[1] = height_diff(y, x);
    v2[2] = longint'(64'(flat_q) * 64'(SQRT2_Q24));
    to_unit(v1, n1);
    to_unit(v2, n2);
    for (int i = 0; i < 3; i++) sm[i] = n1[i] + diag_scale(n2[i]);
    to_unit(sm, n);
    res.nx = encode(n[0]);
    res.ny = encode(n[1]);
    res.nz = encode(n[2]);
    return res;
  endfunction

  assign pending_o = normal_queue.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= 16'd4096;
      height_q <= 16'd4096;
      flat_q <= 16'd256;
      fail_count_o <= 0;
      normals_seen_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_GRID_WIDTH: begin
            width_q <= cfg_data_i;
          end
          CFG_GRID_HEIGHT: begin
            height_q <= cfg_data_i;
          end
          CFG_FLAT_TERM: begin
            flat_q <= cfg_data_i;
          end
          default: begin
          end
        endcase
      end
      if (start_i && !busy_i && !col_i[0] && !row_i[0]) begin
        normal_queue.push_back(surface_normal(col_i, row_i, h_center_i, h_right_i,
          h_up_i, h_left_i, h_down_i, h_down_right_i, h_up_left_i, h_down_left_i,
          h_up_right_i));
      end
      if (done_i) begin
        normals_seen_o <= normals_seen_o + 1;
        if (normal_queue.size() == 0) begin
          $display("%0t: unexpected result x=%h y=%h z=%h", $time, normal_x_i,
            normal_y_i, normal_z_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          normal_t e;
          e = normal_queue.pop_front();
          if (e.nx !== normal_x_i || e.ny !== normal_y_i || e.nz !== normal_z_i) begin
            $display("%0t: normal mismatch expected x=%h y=%h z=%h actual x=%h y=%h z=%h",
              $time, e.nx, e.ny, e.nz, normal_x_i, normal_y_i, normal_z_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heightfield normal map testbench
// Drives windows and configuration writes into the normal map unit under
// several grid sizes and flat terms, with random idle bursts, and lets the
// checker compare every result against its own prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import hfn_pkg::*;

  localparam int LATENCY = 141;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk, rst_n;
  logic start, busy, cfg_valid, cfg_ready, done;
  logic [1:0] cfg_index;
  logic [15:0] cfg_data, col, row;
  logic [15:0] hc, hr, hu, hl, hd, hdr, hul, hdl, hur;
  logic [15:0] nx, ny, nz;
  int fail_count, pending, normals_seen;
  longint cycles;
  int windows_sent;

  heightfield_normal_map_unit u_top (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_o(busy),
    .col_i(col), .row_i(row), .h_center_i(hc), .h_right_i(hr), .h_up_i(hu),
    .h_left_i(hl), .h_down_i(hd), .h_down_right_i(hdr), .h_up_left_i(hul),
    .h_down_left_i(hdl), .h_up_right_i(hur), .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .done_o(done), .normal_x_o(nx), .normal_y_o(ny), .normal_z_o(nz)
  );

  hfn_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_i(busy), .col_i(col),
    .row_i(row), .h_center_i(hc), .h_right_i(hr), .h_up_i(hu), .h_left_i(hl),
    .h_down_i(hd), .h_down_right_i(hdr), .h_up_left_i(hul), .h_down_left_i(hdl),
    .h_up_right_i(hur), .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data), .done_i(done),
    .normal_x_i(nx), .normal_y_i(ny), .normal_z_i(nz),
    .fail_count_o(fail_count), .pending_o(pending), .normals_seen_o(normals_seen)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
  endtask

  function automatic logic [15:0] rand_height(int mode);
    case (mode)
      0: return 16'(32768 + $urandom_range(0, 600) - 300);
      1: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_window(logic [15:0] c, logic [15:0] r, logic [15:0] h[9], bit idle);
    if (idle && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    start <= 1'b1;
    col <= c;
    row <= r;
    hc <= h[0]; hr <= h[1]; hu <= h[2]; hl <= h[3]; hd <= h[4];
    hdr <= h[5]; hul <= h[6]; hdl <= h[7]; hur <= h[8];
    do @(posedge clk); while (busy);
    windows_sent++;
    @(negedge clk);
  endtask

  task automatic random_windows(int n, logic [15:0] w, logic [15:0] hgt, bit idle);
    logic [15:0] h[9];
    logic [15:0] c, r;
    int mode;
    for (int k = 0; k < n; k++) begin
      mode = $urandom_range(0, 2);
      foreach (h[i]) h[i] = rand_height(mode);
      case ($urandom_range(0, 5))
        0: c = 16'($urandom);
        1: c = 16'($urandom_range(0, 3));
        2: c = w - 16'($urandom_range(0, 3));
        default: c = 16'($urandom_range(0, 32'(w) + 2));
      endcase
      case ($urandom_range(0, 5))
        0: r = 16'($urandom);
        1: r = 16'($urandom_range(0, 3));
        2: r = hgt - 16'($urandom_range(0, 3));
        default: r = 16'($urandom_range(0, 32'(hgt) + 2));
      endcase
      if ($urandom_range(0, 4) != 0) begin
        c[0] = 1'b0;
        r[0] = 1'b0;
      end
      send_window(c, r, h, idle);
    end
    start <= 1'b0;
  endtask

  initial begin
    logic [15:0] h[9];
    logic [15:0] widths[6], heights[6], flats[6];
    cycles = 0;
    windows_sent = 0;
    rst_n = 1'b0;
    start = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_GRID_WIDTH;
    cfg_data = '0;
    col = '0; row = '0;
    hc = '0; hr = '0; hu = '0; hl = '0; hd = '0;
    hdr = '0; hul = '0; hdl = '0; hur = '0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed windows under reset settings: flat, extreme slopes, edges, odd positions.
    foreach (h[i]) h[i] = 16'h8000;
    send_window(16'd10, 16'd10, h, 1'b0);
    foreach (h[i]) h[i] = 16'h0000;
    h[3] = 16'hFFFF; h[2] = 16'hFFFF; h[7] = 16'hFFFF; h[6] = 16'hFFFF;
    send_window(16'd10, 16'd10, h, 1'b0);
    foreach (h[i]) h[i] = 16'hFFFF;
    h[3] = 16'h0000; h[2] = 16'h0000; h[7] = 16'h0000; h[6] = 16'h0000;
    send_window(16'd10, 16'd10, h, 1'b0);
    foreach (h[i]) h[i] = 16'($urandom);
    send_window(16'd0, 16'd0, h, 1'b0);
    send_window(16'd2, 16'd2, h, 1'b0);
    send_window(16'd4094, 16'd4094, h, 1'b0);
    send_window(16'd4096, 16'd0, h, 1'b0);
    send_window(16'hFFFE, 16'hFFFE, h, 1'b0);
    send_window(16'd3, 16'd4, h, 1'b0);
    send_window(16'd4, 16'd5, h, 1'b0);
    send_window(16'hFFFF, 16'hFFFF, h, 1'b0);
    start <= 1'b0;
    drain();

    widths  = '{16'd1, 16'hFFFF, 16'd7, 16'd64, 16'd2, 16'd300};
    heights = '{16'd1, 16'hFFFF, 16'd9, 16'd3, 16'd64, 16'd300};
    flats   = '{16'd1, 16'hFFFF, 16'd256, 16'd40, 16'd4000, 16'($urandom_range(1, 65535))};
    for (int p = 0; p < 6; p++) begin
      write_reg(CFG_GRID_WIDTH, widths[p]);
      write_reg(CFG_GRID_HEIGHT, heights[p]);
      write_reg(CFG_FLAT_TERM, flats[p]);
      random_windows(250, widths[p], heights[p], p < 5);
      drain();
    end

    $display("Sent %0d windows over six grid and flat settings; %0d normals checked.",
      windows_sent, normals_seen);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
rtl/hfn_pkg.sv
rtl/hfn_front.sv
rtl/hfn_unitize.sv
rtl/hfn_blend.sv
rtl/hfn_encode.sv
rtl/heightfield_normal_map_unit.sv
bench/hfn_checker.sv
bench/tb.sv
